// File: design/fdsg_pkg.sv
// ----------------------------------------------------------------------------
// fdsg_pkg
// Shared types and fixed widths for the filled disc span generator.
// ----------------------------------------------------------------------------
package fdsg_pkg;

  localparam int COORD_W = 16;  // input coordinate width
  localparam int DIFF_W  = 17;  // coordinate difference and multiplier operand width
  localparam int PROD_W  = 34;  // multiplier product width
  localparam int SUM_W   = 35;  // sum of two squares
  localparam int OUT_W   = 17;  // span coordinate width

  // Status of the shared square root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } fdsg_sqrt_stat_t;

endpackage

// File: design/fdsg_mul.sv
// ----------------------------------------------------------------------------
// fdsg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fdsg_mul
  import fdsg_pkg::*;
(
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] mul_a,
  input  logic signed [DIFF_W-1:0] mul_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// File: design/fdsg_isqrt.sv
// ----------------------------------------------------------------------------
// fdsg_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fdsg_isqrt
  import fdsg_pkg::*;
#(
  parameter int RW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] operand,
  output logic [RW-1:0]   root,
  output fdsg_sqrt_stat_t stat
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] val_r,  val_nxt;
  logic [RW:0]     rem_r,  rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r,  cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;

  // Classic digit-by-digit method: bring down two operand bits, try
  // subtracting 4*root + 1.
  assign rem_sh = {rem_r, val_r[2*RW-1 -: 2]};
  assign trial  = (RW+3)'({root_r, 2'b01});

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = val_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = (RW+1)'(rem_sh - trial);
        root_nxt = RW'({root_r, 1'b1});
      end else begin
        rem_nxt  = (RW+1)'(rem_sh);
        root_nxt = RW'({root_r, 1'b0});
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: design/filled_disc_span_generator.sv
// Each accepted circle takes one square root for its radius (skipped when the
// radius saturates) and one for each of its 2r+1 spans, each RW bits wide,
// where RW = clog2(MAX_RADIUS+1); the square root yields one bit per cycle.
// A new circle is taken once the last span sits in the output register.
// Reset (synchronous, active low) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// filled_disc_span_generator
// Rasterizes a filled circle into one horizontal span per row, using a shared
// multiplier and a shared iterative square root under a small sequencer.
// ----------------------------------------------------------------------------
module filled_disc_span_generator
  import fdsg_pkg::*;
#(
  parameter int MAX_RADIUS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_edge_x,
  input  logic signed [COORD_W-1:0] in_edge_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_row_y,
  output logic signed [OUT_W-1:0]   out_span_left,
  output logic signed [OUT_W-1:0]   out_span_right,
  output logic                      out_radius_clipped,
  output logic                      out_last_span
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam logic [SUM_W-1:0] LIM = SUM_W'((MAX_RADIUS + 1) * (MAX_RADIUS + 1));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_RSQ   = 4'd5;
  localparam logic [3:0] S_RSQ2  = 4'd6;
  localparam logic [3:0] S_DYSQ  = 4'd7;
  localparam logic [3:0] S_DYSQ2 = 4'd8;
  localparam logic [3:0] S_HWAIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]                state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic signed [DIFF_W-1:0]  ddx_r, ddy_r;
  logic [PROD_W-1:0]         sq_r;
  logic [RW-1:0]             r_r, r_nxt;
  logic                      clip_r, clip_nxt;
  logic [2*RW-1:0]           rr_r;
  logic signed [RW:0]        dy_r, dy_nxt;
  logic [RW-1:0]             h_r;

  logic signed [OUT_W-1:0]   row_y_r, span_left_r, span_right_r;
  logic                      clipped_r, last_r;

  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]          d2;

  logic                      sq_start;
  logic [2*RW-1:0]           sq_operand;
  logic [RW-1:0]             sq_root;
  fdsg_sqrt_stat_t           sq_stat;

  logic                      in_fire, load_out, dy_at_r;

  fdsg_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  fdsg_isqrt #(.RW(RW)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_operand),
    .root    (sq_root),
    .stat    (sq_stat)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign d2       = SUM_W'(sq_r) + SUM_W'(unsigned'(prod));
  assign dy_at_r  = (dy_r == signed'({1'b0, r_r}));
  assign load_out = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Multiplier operands; the product is registered and appears in the following cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX: begin
        mul_a = ddx_r;
        mul_b = ddx_r;
      end
      S_SQY: begin
        mul_a = ddy_r;
        mul_b = ddy_r;
      end
      S_RSQ: begin
        mul_a = DIFF_W'({1'b0, r_r});
        mul_b = DIFF_W'({1'b0, r_r});
      end
      S_DYSQ: begin
        mul_a = DIFF_W'(dy_r);
        mul_b = DIFF_W'(dy_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    r_nxt         = r_r;
    clip_nxt      = clip_r;
    dy_nxt        = dy_r;
    sq_start      = 1'b0;
    sq_operand    = d2[2*RW-1:0];
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SQX;
        end
      end
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SUM;
      S_SUM: begin
        if (d2 >= LIM) begin
          r_nxt     = RW'(MAX_RADIUS);
          clip_nxt  = 1'b1;
          state_nxt = S_RSQ;
        end else begin
          clip_nxt  = 1'b0;
          sq_start  = 1'b1;
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (sq_stat.done) begin
          r_nxt     = sq_root;
          state_nxt = S_RSQ;
        end
      end
      S_RSQ:   state_nxt = S_RSQ2;
      S_RSQ2: begin
        dy_nxt    = -signed'({1'b0, r_r});
        state_nxt = S_DYSQ;
      end
      S_DYSQ:  state_nxt = S_DYSQ2;
      S_DYSQ2: begin
        // dy*dy never exceeds r*r, so the difference cannot wrap.
        sq_operand = rr_r - prod[2*RW-1:0];
        sq_start   = 1'b1;
        state_nxt  = S_HWAIT;
      end
      S_HWAIT: begin
        if (sq_stat.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (dy_at_r) begin
            state_nxt = S_IDLE;
          end else begin
            dy_nxt    = dy_r + (RW+1)'(1);
            state_nxt = S_DYSQ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    clip_r <= clip_nxt;
    dy_r   <= dy_nxt;
    if (in_fire) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      ddx_r <= DIFF_W'(in_edge_x) - DIFF_W'(in_center_x);
      ddy_r <= DIFF_W'(in_edge_y) - DIFF_W'(in_center_y);
    end
    if (state_r == S_SQY) begin
      sq_r <= unsigned'(prod);
    end
    if (state_r == S_RSQ2) begin
      rr_r <= prod[2*RW-1:0];
    end
    if (state_r == S_HWAIT && sq_stat.done) begin
      h_r <= sq_root;
    end
    if (load_out) begin
      row_y_r      <= OUT_W'(cy_r) + OUT_W'(dy_r);
      span_left_r  <= OUT_W'(cx_r) - signed'(OUT_W'({1'b0, h_r}));
      span_right_r <= OUT_W'(cx_r) + signed'(OUT_W'({1'b0, h_r}));
      clipped_r    <= clip_r;
      last_r       <= dy_at_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_y          = row_y_r;
  assign out_span_left      = span_left_r;
  assign out_span_right     = span_right_r;
  assign out_radius_clipped = clipped_r;
  assign out_last_span      = last_r;

`ifndef SYNTHESIS
  // The square root unit is never restarted while it is still iterating.
  a_sqrt_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  // A root result only arrives while the sequencer is waiting for one.
  a_sqrt_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (state_r == S_RWAIT || state_r == S_HWAIT))
    else $error("unexpected square root result");

  // Row offset stays within the radius while rows are produced.
  a_dy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DYSQ || state_r == S_DYSQ2 || state_r == S_HWAIT || state_r == S_EMIT)
    |-> (dy_r <= signed'({1'b0, r_r}) && dy_r >= -signed'({1'b0, r_r})))
    else $error("row offset outside radius");
`endif

endmodule
